[rtl/core/gha_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the generational handle allocator.
// No dependencies; imported by the top level and by gha_exec.
package gha_pkg;

  // Sizing
  localparam int SLOT_COUNT = 256;
  localparam int GEN_BITS   = 16;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = IDX_W + 1;

  // Command codes (code 3 is served as a check)
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_CHECK   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_STALE    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Request word
  typedef struct packed {
    logic [1:0]          cmd;
    logic [IDX_W-1:0]    handle_index;
    logic [GEN_BITS-1:0] handle_generation;
  } gha_req_t;

  // Result word
  typedef struct packed {
    logic [2:0]          status;
    logic [IDX_W-1:0]    out_index;
    logic [GEN_BITS-1:0] out_generation;
  } gha_res_t;

  // Free queue entry: released index and the generation it gets on reuse
  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [GEN_BITS-1:0] gen;
  } gha_qent_t;

  // Memory write commands and queue read pointer from the execute stage
  typedef struct packed {
    logic                gen_we;
    logic [IDX_W-1:0]    gen_addr;
    logic [GEN_BITS-1:0] gen_data;
    logic                q_we;
    logic [IDX_W-1:0]    q_addr;
    gha_qent_t           q_data;
    logic [IDX_W-1:0]    head_next;
  } gha_wr_t;

endpackage

[rtl/core/generational_handle_allocator.sv]
`timescale 1ns / 1ps
// Top level of the generational handle allocator: request register,
// generation table and free queue RAMs with forwarding. Uses gha_pkg,
// gha_ram and gha_exec.
//
// Usage:
//   Requests (allocate, release, check) are taken on a clock edge with
//   start high; busy is always low, so one request is taken every cycle.
//   Each request gives exactly one result word, shown for one cycle with
//   result_valid high after passing the request register and the result
//   register. Results come in request order at one per cycle; the
//   receiver cannot stall them. The enable register is written through
//   cfg_valid/cfg_data (cfg_ready is always high); the user must write it
//   only while no request is in flight, which the block does not enforce.
//   The request is registered while the generation table (indexed by the
//   request) and the free queue head are read; the next cycle decides the
//   request and writes back. Writes landing on the address just read are
//   forwarded, so back-to-back requests on one slot see fresh data.
//   Reset (rst, synchronous) clears valid bits, counters and the enable
//   register; the RAMs need no clearing pass and requests are taken from
//   the first cycle after reset.
module generational_handle_allocator
  import gha_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  gha_req_t request,
  output logic     result_valid,
  output gha_res_t result,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  logic                req_valid;
  gha_req_t            req;
  gha_wr_t             wr;
  logic [GEN_BITS-1:0] gen_rd;
  logic [GEN_BITS-1:0] gen_cur;
  logic                gen_fwd_hit;
  logic [GEN_BITS-1:0] gen_fwd_data;
  gha_qent_t           q_rd;
  gha_qent_t           q_cur;
  logic                q_fwd_hit;
  gha_qent_t           q_fwd_data;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    req <= request;
  end

  // Forwarding of writes that coincide with the read of the same entry
  always_ff @(posedge clk) begin
    gen_fwd_hit  <= wr.gen_we && (wr.gen_addr == request.handle_index);
    gen_fwd_data <= wr.gen_data;
    q_fwd_hit    <= wr.q_we && (wr.q_addr == wr.head_next);
    q_fwd_data   <= wr.q_data;
  end

  assign gen_cur = gen_fwd_hit ? gen_fwd_data : gen_rd;
  assign q_cur   = q_fwd_hit ? q_fwd_data : q_rd;

  // Generation table
  gha_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (GEN_BITS)
  ) u_gen_ram (
    .clk   (clk),
    .we    (wr.gen_we),
    .waddr (wr.gen_addr),
    .wdata (wr.gen_data),
    .raddr (request.handle_index),
    .rdata (gen_rd)
  );

  // Free queue
  gha_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH ($bits(gha_qent_t))
  ) u_free_ram (
    .clk   (clk),
    .we    (wr.q_we),
    .waddr (wr.q_addr),
    .wdata (wr.q_data),
    .raddr (wr.head_next),
    .rdata (q_rd)
  );

  // Decision, state and result register
  gha_exec u_exec (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req          (req),
    .gen_cur      (gen_cur),
    .q_cur        (q_cur),
    .result_valid (result_valid),
    .result       (result),
    .wr           (wr)
  );

endmodule

[rtl/core/gha_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module gha_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/gha_exec.sv]
`timescale 1ns / 1ps
// Execute stage: decides each request, owns valid bits, counters, the
// enable register and the result register. Depends on gha_pkg.
module gha_exec
  import gha_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_data,
  input  logic                req_valid,
  input  gha_req_t            req,
  input  logic [GEN_BITS-1:0] gen_cur,
  input  gha_qent_t           q_cur,
  output logic                result_valid,
  output gha_res_t            result,
  output gha_wr_t             wr
);

  logic                  enabled;
  logic [SLOT_COUNT-1:0] valid_bits;
  logic [SLOT_COUNT-1:0] valid_bits_next;
  logic [CNT_W-1:0]      slots_used;
  logic [CNT_W-1:0]      slots_used_next;
  logic [IDX_W-1:0]      free_head;
  logic [IDX_W-1:0]      free_tail;
  logic [IDX_W-1:0]      free_tail_next;
  logic [CNT_W-1:0]      free_count;
  logic [CNT_W-1:0]      free_count_next;
  gha_res_t              result_next;
  logic                  in_range;
  logic                  live;

  assign in_range = {1'b0, req.handle_index} < slots_used;
  assign live     = valid_bits[req.handle_index] && (gen_cur == req.handle_generation);

  // Request decision and next state
  always_comb begin
    result_next     = '0;
    wr              = '0;
    wr.head_next    = free_head;
    valid_bits_next = valid_bits;
    slots_used_next = slots_used;
    free_tail_next  = free_tail;
    free_count_next = free_count;
    if (req_valid) begin
      if (req.cmd == CMD_ALLOC) begin
        if (!enabled) begin
          result_next.status = ST_REJECTED;
        end else if (free_count != '0) begin
          // recycle oldest released slot
          result_next.status         = ST_OK;
          result_next.out_index      = q_cur.idx;
          result_next.out_generation = q_cur.gen;
          wr.gen_we                  = 1'b1;
          wr.gen_addr                = q_cur.idx;
          wr.gen_data                = q_cur.gen;
          wr.head_next               = free_head + 1'b1;
          free_count_next            = free_count - 1'b1;
          valid_bits_next[q_cur.idx] = 1'b1;
        end else if (slots_used < CNT_W'(SLOT_COUNT)) begin
          // fresh slot, generation zero
          result_next.status         = ST_OK;
          result_next.out_index      = slots_used[IDX_W-1:0];
          result_next.out_generation = '0;
          wr.gen_we                  = 1'b1;
          wr.gen_addr                = slots_used[IDX_W-1:0];
          wr.gen_data                = '0;
          slots_used_next            = slots_used + 1'b1;
          valid_bits_next[slots_used[IDX_W-1:0]] = 1'b1;
        end else begin
          result_next.status = ST_FULL;
        end
      end else if (!in_range) begin
        result_next.status    = ST_RANGE;
        result_next.out_index = req.handle_index;
      end else begin
        result_next.out_index      = req.handle_index;
        result_next.out_generation = gen_cur;
        if (!live) begin
          result_next.status = ST_STALE;
        end else begin
          result_next.status = ST_OK;
          if (req.cmd == CMD_RELEASE) begin
            // free the slot; queue it with its next generation
            valid_bits_next[req.handle_index] = 1'b0;
            wr.q_we         = 1'b1;
            wr.q_addr       = free_tail;
            wr.q_data.idx   = req.handle_index;
            wr.q_data.gen   = gen_cur + 1'b1;
            free_tail_next  = free_tail + 1'b1;
            free_count_next = free_count + 1'b1;
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b0;
      valid_bits   <= '0;
      slots_used   <= '0;
      free_head    <= '0;
      free_tail    <= '0;
      free_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        enabled <= cfg_data;
      end
      valid_bits   <= valid_bits_next;
      slots_used   <= slots_used_next;
      free_head    <= wr.head_next;
      free_tail    <= free_tail_next;
      free_count   <= free_count_next;
      result_valid <= req_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= slots_used)
    else $error("free count exceeds handed-out slots");

  a_queue_ptrs: assert property (@(posedge clk) disable iff (rst)
    (free_tail - free_head) == free_count[IDX_W-1:0])
    else $error("free queue pointers disagree with count");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    req_valid |=> result_valid)
    else $error("request produced no result");

  a_full_cond: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req.cmd == CMD_ALLOC && enabled && free_count == '0
     && slots_used == CNT_W'(SLOT_COUNT)) |=> (result.status == ST_FULL))
    else $error("exhausted allocate not reported full");

endmodule
